/* src/tfe_pkg.sv */
// ----------------------------------------------------------------------------
// tfe_pkg: shared types and constants for the trap fitness evaluator
// Holds the mode codes, register indexes, trap tables and the word passed
// from the front to the back of the evaluator.
// ----------------------------------------------------------------------------
package tfe_pkg;

    localparam int MAX_BITS_DEF = 256;
    localparam int FIT_W        = 60;
    localparam int SUM_W        = 64;
    localparam int CFG_W        = 9;

    localparam logic [3:0] MODE_ONEMAX = 4'd0;
    localparam logic [3:0] MODE_TRAP   = 4'd1;
    localparam logic [3:0] MODE_CYCLIC = 4'd2;
    localparam logic [3:0] MODE_FOLD   = 4'd3;
    localparam logic [3:0] MODE_FOLD2  = 4'd4;
    localparam logic [3:0] MODE_FOLD3  = 4'd5;
    localparam logic [3:0] MODE_LIN    = 4'd6;
    localparam logic [3:0] MODE_EXP    = 4'd7;
    localparam logic [3:0] MODE_MIX456 = 4'd8;
    localparam logic [3:0] MODE_MIX37  = 4'd9;

    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_BIT_COUNT = 1'b1;

    // one block-level contribution handed to the accumulator side
    typedef struct packed {
        logic        add_main;   // add main_val (shifted/scaled) to main sum
        logic [8:0]  main_val;   // trap level x420
        logic [5:0]  weight_idx; // block index for linear / exponential
        logic        add_alt;    // folded modes: also add alt values; cyclic: add alt_a to main sum
        logic [8:0]  alt_a;
        logic [8:0]  alt_b;
        logic        last;       // emit result after this
        logic        length_error;
        logic        clear;      // first bit of a chromosome
        logic [3:0]  mode;
    } tfe_op_t;

    function automatic logic [8:0] trap_val(input logic [2:0] u, input logic [2:0] k);
        logic [8:0] low;
        logic [8:0] step;
        logic [8:0] r;
        begin
            low  = 9'd0;
            step = 9'd0;
            unique case (k)
                3'd3:    begin low = 9'd280; step = 9'd140; end
                3'd4:    begin low = 9'd315; step = 9'd105; end
                3'd5:    begin low = 9'd336; step = 9'd84;  end
                3'd6:    begin low = 9'd350; step = 9'd70;  end
                3'd7:    begin low = 9'd360; step = 9'd60;  end
                default: begin low = 9'd0;   step = 9'd0;   end
            endcase
            if (k < 3'd3)
                r = 9'd0;
            else if (u == k)
                r = 9'd420;
            else if (u > k)
                r = 9'd0;
            else
                r = 9'(low - 9'(u * step));
            trap_val = r;
        end
    endfunction

    function automatic logic [8:0] fold_val(input logic [2:0] u);
        logic [8:0] r;
        begin
            unique case (u)
                3'd0:    r = 9'd420;
                3'd2:    r = 9'd168;
                3'd3:    r = 9'd336;
                3'd4:    r = 9'd168;
                3'd6:    r = 9'd420;
                default: r = 9'd0;
            endcase
            fold_val = r;
        end
    endfunction

    function automatic logic [4:0] block_size(input logic [3:0] md);
        logic [4:0] r;
        begin
            unique case (md)
                MODE_ONEMAX: r = 5'd1;
                MODE_CYCLIC: r = 5'd4;
                MODE_FOLD, MODE_FOLD2, MODE_FOLD3: r = 5'd6;
                MODE_MIX456: r = 5'd15;
                MODE_MIX37:  r = 5'd25;
                default:     r = 5'd5;
            endcase
            block_size = r;
        end
    endfunction

endpackage

/* src/tfe_fifo.sv */
// ----------------------------------------------------------------------------
// tfe_fifo: short queue between the front and the back of the evaluator
// Two-entry register queue with full throughput; flags are decoded from a registered count.
// ----------------------------------------------------------------------------
module tfe_fifo
    import tfe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    flush,
    input  logic    wr_en,
    input  tfe_op_t wr_data,
    output logic    full,
    input  logic    rd_en,
    output tfe_op_t rd_data,
    output logic    empty
);

    tfe_op_t    mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (flush)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= ~wptr_reg;
            if (rd_en)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= 2'(cnt_reg + {1'b0, wr_en} - {1'b0, rd_en});
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !rd_en |-> !wr_en) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !rd_en) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");

endmodule

/* src/tfe_front.sv */
// ----------------------------------------------------------------------------
// tfe_front: bit counting and block classification
// Tracks position, block and segment counts per bit and emits one operation
// per accepted bit carrying the finished block's trap level, if any.
// ----------------------------------------------------------------------------
module tfe_front
    import tfe_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       flush,
    input  logic [3:0] mode,
    input  logic [8:0] bit_count,
    input  logic       bit_valid,
    input  logic       gene_bit,
    output tfe_op_t    op
);

    logic [8:0] pos_reg, pos_next;
    logic [2:0] ones_reg, ones_next;
    logic [2:0] pa_reg, pa_next;
    logic [2:0] pb_reg, pb_next;
    logic [5:0] bidx_reg, bidx_next;
    logic [2:0] seg_reg, seg_next;
    logic       first_reg, first_next;
    logic [2:0] j_reg, j_next;        // position within current block
    logic [8:0] start_reg, start_next; // start of the current mix segment
    logic [8:0] len;
    logic [8:0] full_len;
    logic [4:0] bsz;
    logic [4:0] rem;
    logic [4:0] quo_k;
    logic [6:0] q4;
    logic [8:0] q5, q6, q15, q25, qb;
    logic [5:0] m_mix;
    logic [2:0] k;
    logic [2:0] seg_size;
    logic       is_last;
    logic [2:0] ma, mb;

    // effective length
    always_comb
    begin
        if (bit_count == 9'd0)
            len = 9'd1;
        else if ({1'b0, bit_count} > 10'(MAX_BITS))
            len = 9'(MAX_BITS);
        else
            len = bit_count;
    end

    // quotients by reciprocal multiplication, exact for len <= 256
    assign q4  = 7'(len >> 2);
    assign q5  = 9'((18'(len) * 18'd205) >> 10);
    assign q6  = 9'((18'(len) * 18'd171) >> 10);
    assign q15 = 9'((18'(len) * 18'd137) >> 11);
    assign q25 = 9'((18'(len) * 18'd82) >> 11);

    always_comb
    begin
        unique case (mode)
            MODE_ONEMAX:                       qb = len;
            MODE_CYCLIC:                       qb = {2'b00, q4};
            MODE_FOLD, MODE_FOLD2, MODE_FOLD3: qb = q6;
            MODE_MIX456:                       qb = q15;
            MODE_MIX37:                        qb = q25;
            default:                           qb = q5;
        endcase
    end

    assign bsz     = block_size(mode);
    assign full_len = 9'(qb * 9'(bsz));
    assign rem     = 5'(len - full_len);
    assign quo_k   = 5'd0;
    assign m_mix   = (mode == MODE_MIX456) ? 6'(q15) : 6'(q25);
    assign is_last = (10'(pos_reg) + 10'd1 >= 10'(len));

    always_comb
    begin
        unique case (seg_reg)
            3'd0:    seg_size = (mode == MODE_MIX456) ? 3'd4 : 3'd3;
            3'd1:    seg_size = (mode == MODE_MIX456) ? 3'd5 : 3'd4;
            3'd2:    seg_size = (mode == MODE_MIX456) ? 3'd6 : 3'd5;
            3'd3:    seg_size = 3'd6;
            default: seg_size = 3'd7;
        endcase
    end

    assign k = (mode == MODE_FOLD || mode == MODE_FOLD2 || mode == MODE_FOLD3) ? 3'd6 : 3'd5;
    assign ma = (j_reg < 3'd3) ? {2'b0, ~gene_bit} : {2'b0, gene_bit};
    assign mb = j_reg[0] ? {2'b0, ~gene_bit} : {2'b0, gene_bit};

    always_comb
    begin
        logic [2:0] u;
        logic [2:0] ua;
        logic [2:0] ub;
        logic [8:0] nstart;
        pos_next   = is_last ? 9'd0 : 9'(pos_reg + 9'd1);
        ones_next  = ones_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        bidx_next  = bidx_reg;
        seg_next   = seg_reg;
        first_next = first_reg;
        j_next     = j_reg;
        start_next = start_reg;
        u = 3'd0; ua = 3'd0; ub = 3'd0; nstart = 9'd0;
        op = '0;
        op.mode         = mode;
        op.weight_idx   = bidx_reg;
        op.last         = is_last;
        op.length_error = (rem != 5'd0);
        op.clear        = (pos_reg == 9'd0);

        unique case (mode)
            MODE_ONEMAX:
            begin
                op.add_main = gene_bit;
                op.main_val = 9'd420;
            end
            MODE_CYCLIC:
            begin
                if (10'(pos_reg) <= 10'({q4, 2'b00}))
                begin
                    if (pos_reg == 9'd0)
                    begin
                        ones_next  = {2'b0, gene_bit};
                        first_next = gene_bit;
                        u          = {2'b0, gene_bit};
                    end
                    else if (pos_reg[1:0] == 2'd0)
                    begin
                        op.add_main = 1'b1;
                        op.main_val = trap_val(3'(ones_reg + {2'b0, gene_bit}), 3'd5);
                        ones_next   = {2'b0, gene_bit};
                        u           = {2'b0, gene_bit};
                    end
                    else
                    begin
                        ones_next = 3'(ones_reg + {2'b0, gene_bit});
                        u         = ones_next;
                    end
                    if (is_last && len[1:0] == 2'd0 && q4 != 7'd0)
                    begin
                        // the wrap block closes on the same bit; fold both in
                        op.add_alt = 1'b1;
                        op.alt_a   = trap_val(3'(u + {2'b0,
                            (pos_reg == 9'd0) ? gene_bit : first_reg}), 3'd5);
                    end
                end
            end
            MODE_MIX456, MODE_MIX37:
            begin
                if (m_mix != 6'd0 && seg_reg < ((mode == MODE_MIX456) ? 3'd3 : 3'd5)
                    && pos_reg >= start_reg)
                begin
                    ones_next = (j_reg == 3'd0) ? {2'b0, gene_bit}
                                                : 3'(ones_reg + {2'b0, gene_bit});
                    if (j_reg == 3'(seg_size - 3'd1))
                    begin
                        op.add_main = 1'b1;
                        op.main_val = trap_val(ones_next, seg_size);
                        j_next      = 3'd0;
                        if (bidx_reg + 6'd1 >= m_mix)
                        begin
                            bidx_next = 6'd0;
                            seg_next  = 3'(seg_reg + 3'd1);
                            nstart    = 9'(pos_reg + 9'd1);
                            start_next = nstart;
                        end
                        else
                            bidx_next = 6'(bidx_reg + 6'd1);
                    end
                    else
                        j_next = 3'(j_reg + 3'd1);
                end
            end
            default:
            begin
                if (pos_reg < full_len)
                begin
                    ones_next = (j_reg == 3'd0) ? {2'b0, gene_bit}
                                                : 3'(ones_reg + {2'b0, gene_bit});
                    pa_next   = (j_reg == 3'd0) ? ma : 3'(pa_reg + ma);
                    pb_next   = (j_reg == 3'd0) ? mb : 3'(pb_reg + mb);
                    if (j_reg == 3'(k - 3'd1))
                    begin
                        op.add_main = 1'b1;
                        j_next      = 3'd0;
                        bidx_next   = 6'(bidx_reg + 6'd1);
                        if (k == 3'd6)
                        begin
                            op.main_val = fold_val(ones_next);
                            op.add_alt  = 1'b1;
                            op.alt_a    = fold_val(pa_next);
                            op.alt_b    = fold_val(pb_next);
                        end
                        else
                            op.main_val = trap_val(ones_next, 3'd5);
                    end
                    else
                        j_next = 3'(j_reg + 3'd1);
                end
            end
        endcase
        ua = u;
        ub = ua;
        if (is_last)
        begin
            ones_next = 3'd0; pa_next = 3'd0; pb_next = 3'd0; bidx_next = 6'd0;
            seg_next = 3'd0; first_next = 1'b0; j_next = 3'd0; start_next = 9'd0;
        end
        if (ub == 3'd7 && quo_k == 5'd1)
            op.clear = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; ones_reg <= '0; pa_reg <= '0; pb_reg <= '0;
            bidx_reg <= '0; seg_reg <= '0; first_reg <= 1'b0; j_reg <= '0;
            start_reg <= '0;
        end
        else if (flush)
        begin
            pos_reg <= '0; ones_reg <= '0; pa_reg <= '0; pb_reg <= '0;
            bidx_reg <= '0; seg_reg <= '0; first_reg <= 1'b0; j_reg <= '0;
            start_reg <= '0;
        end
        else if (bit_valid)
        begin
            pos_reg <= pos_next; ones_reg <= ones_next; pa_reg <= pa_next;
            pb_reg <= pb_next; bidx_reg <= bidx_next; seg_reg <= seg_next;
            first_reg <= first_next; j_reg <= j_next; start_reg <= start_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        10'(pos_reg) < 10'(MAX_BITS)) else $error("bit position out of range");
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        bit_valid && !flush && is_last |=> pos_reg == 9'd0) else $error("no wrap");
    a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
        j_reg < 3'd7) else $error("block offset out of range");

endmodule

/* src/tfe_back.sv */
// ----------------------------------------------------------------------------
// tfe_back: accumulation and result register
// Adds block contributions (plain, linearly or exponentially weighted) and
// the folded alternatives, and presents the fitness of each chromosome.
// ----------------------------------------------------------------------------
module tfe_back
    import tfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        flush,
    input  logic        op_valid,
    input  tfe_op_t     op,
    output logic        op_ready,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [59:0] fitness,
    output logic        length_error
);

    logic [SUM_W-1:0] main_reg;
    logic [15:0]      alta_reg;
    logic [15:0]      altb_reg;
    logic             res_valid_reg;
    logic [59:0]      fit_reg;
    logic             lerr_reg;
    logic [SUM_W-1:0] base_main;
    logic [15:0]      base_a, base_b;
    logic [SUM_W-1:0] add_val;
    logic [SUM_W-1:0] main_sum;
    logic [15:0]      sum_a, sum_b;
    logic [SUM_W-1:0] fit;
    logic             take;

    // only a closing request has to wait for the result register
    assign op_ready = !res_valid_reg || res_ready || !op.last;
    assign take     = op_valid && op_ready;

    assign base_main = op.clear ? '0 : main_reg;
    assign base_a    = op.clear ? '0 : alta_reg;
    assign base_b    = op.clear ? '0 : altb_reg;

    // linear weight is a 9x7 multiply, exponential a shift
    always_comb
    begin
        add_val = '0;
        if (op.add_main)
        begin
            if (op.mode == MODE_LIN)
                add_val = SUM_W'(16'(op.main_val) * 16'({1'b0, op.weight_idx} + 7'd1));
            else if (op.mode == MODE_EXP)
                add_val = SUM_W'(op.main_val) << op.weight_idx;
            else
                add_val = SUM_W'(op.main_val);
        end
    end

    always_comb
    begin
        main_sum = base_main + add_val;
        sum_a    = base_a;
        sum_b    = base_b;
        if (op.add_alt)
        begin
            if (op.mode == MODE_CYCLIC)
                main_sum = main_sum + SUM_W'(op.alt_a);
            else
            begin
                sum_a = 16'(base_a + 16'(op.alt_a));
                sum_b = 16'(base_b + 16'(op.alt_b));
            end
        end
        fit = main_sum;
        if ((op.mode == MODE_FOLD2 || op.mode == MODE_FOLD3) && SUM_W'(sum_a) > fit)
            fit = SUM_W'(sum_a);
        if (op.mode == MODE_FOLD3 && SUM_W'(sum_b) > fit)
            fit = SUM_W'(sum_b);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            main_reg <= main_sum;
            alta_reg <= sum_a;
            altb_reg <= sum_b;
            if (op.last)
            begin
                fit_reg  <= fit[59:0];
                lerr_reg <= op.length_error;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (flush)
            res_valid_reg <= 1'b0;
        else if (take && op.last)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    assign res_valid    = res_valid_reg;
    assign fitness      = fit_reg;
    assign length_error = lerr_reg;

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n || flush)
        res_valid_reg && !res_ready |=> res_valid_reg && $stable(fit_reg))
        else $error("result dropped while stalled");
    a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> op_ready) else $error("op taken without ready");
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        take && op.last && !flush |=> res_valid_reg) else $error("missing result");

endmodule

/* src/trap_fitness_evaluator.sv */
// ----------------------------------------------------------------------------
// trap_fitness_evaluator: streaming deceptive trap fitness
//
//  channel | dir | contents
//  s_axis  | in  | tdata[0] gene_bit
//  m_axis  | out | tdata[59:0] fitness, tdata[60] length_error
//  cfg     | in  | cfg_we, cfg_index (0 mode, 1 bit_count), cfg_data
//
// One bit per cycle while the queue has room; the last bit of a chromosome is
// registered in the queue, then its result in the output register.
// A two-entry queue between classification and accumulation, and the back
// accumulating while a result waits, keep the input flowing until the next
// chromosome closes. Any register write restarts the chromosome.
// Reset: mode 1, bit_count 250.
// ----------------------------------------------------------------------------
module trap_fitness_evaluator
    import tfe_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] gene_bit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [59:0] fitness, [60] length_error
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    logic [3:0] mode_reg;
    logic [8:0] bit_count_reg;
    tfe_op_t    front_op;
    tfe_op_t    q_op;
    logic       q_full, q_empty, q_rd;
    logic       back_ready;
    logic       acc;
    logic [59:0] fitness;
    logic       length_error;

    assign s_axis_tready = !q_full;
    assign acc           = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_TRAP;
            bit_count_reg <= 9'd250;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[3:0];
                REG_BIT_COUNT: bit_count_reg <= cfg_data;
                default:       mode_reg      <= mode_reg;
            endcase
        end
    end

    tfe_front #(.MAX_BITS(MAX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .flush(cfg_we), .mode(mode_reg),
        .bit_count(bit_count_reg), .bit_valid(acc), .gene_bit(s_axis_tdata[0]),
        .op(front_op)
    );

    tfe_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .flush(cfg_we), .wr_en(acc), .wr_data(front_op),
        .full(q_full), .rd_en(q_rd), .rd_data(q_op), .empty(q_empty)
    );

    assign q_rd = !q_empty && back_ready;

    tfe_back u_back (
        .clk(clk), .rst_n(rst_n), .flush(cfg_we), .op_valid(!q_empty), .op(q_op),
        .op_ready(back_ready), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .fitness(fitness), .length_error(length_error)
    );

    assign m_axis_tdata = {3'b000, length_error, fitness};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n || cfg_we)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
    a_ready_q: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_axis_tready) else $error("ready while queue full");
    a_cfg_flush: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !m_axis_tvalid) else $error("result survives config write");

endmodule

/* sim/tb_trap_fitness_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trap_fitness_evaluator: self-checking bench for the trap fitness evaluator
// Streams chromosome bits under bursty input and a stalling output, predicts
// each fitness word with an in-bench scorer and compares every result.
// ----------------------------------------------------------------------------
module tb_trap_fitness_evaluator;
    import tfe_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] gene_bit
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [59:0] fitness, [60] length_error
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    trap_fitness_evaluator DUT (.*);

    typedef struct packed {
        logic [59:0] fitness;
        logic        length_error;
    } score_t;

    score_t      score_q[$];
    int          mismatches = 0;
    int          scores_seen = 0;
    int          bits_sent = 0;
    longint      cycle_cnt = 0;
    localparam longint CYCLE_LIMIT = 4000000;

    // scorer state
    logic [3:0]  sc_mode;
    logic [8:0]  sc_len_reg;
    int unsigned sc_pos, sc_ones, sc_pa, sc_pb, sc_blk, sc_seg, sc_first;
    logic [63:0] sc_main;
    logic [15:0] sc_alt_a, sc_alt_b;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("trap_fitness_evaluator verification failed");
            $finish;
        end
    end

    function automatic int unsigned trap_level(int unsigned u, int unsigned k);
        int unsigned lo, st;
        case (k)
            3: begin lo = 280; st = 140; end
            4: begin lo = 315; st = 105; end
            5: begin lo = 336; st = 84; end
            6: begin lo = 350; st = 70; end
            7: begin lo = 360; st = 60; end
            default: return 0;
        endcase
        if (u == k) return 420;
        if (u > k) return 0;
        return lo - u * st;
    endfunction

    function automatic int unsigned fold_level(int unsigned u);
        case (u)
            0, 6: return 420;
            2, 4: return 168;
            3: return 336;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned grain(logic [3:0] md);
        case (md)
            MODE_ONEMAX: return 1;
            MODE_CYCLIC: return 4;
            MODE_FOLD, MODE_FOLD2, MODE_FOLD3: return 6;
            MODE_MIX456: return 15;
            MODE_MIX37: return 25;
            default: return 5;
        endcase
    endfunction

    task automatic clear_scorer();
        sc_pos = 0; sc_ones = 0; sc_pa = 0; sc_pb = 0; sc_blk = 0; sc_seg = 0;
        sc_first = 0; sc_main = '0; sc_alt_a = '0; sc_alt_b = '0;
    endtask

    task automatic score_bit(input int unsigned b);
        int unsigned len, p, k, j, ma, mb, m, start, nseg, grp;
        int unsigned sz[5];
        logic [63:0] fit;
        score_t r;
        len = sc_len_reg;
        if (len < 1) len = 1;
        if (len > MAX_BITS_DEF) len = MAX_BITS_DEF;
        p = sc_pos;
        case (sc_mode)
            MODE_ONEMAX: if (b) sc_main += 420;
            MODE_CYCLIC:
            begin
                m = len / 4;
                if (p <= 4 * m)
                begin
                    if (p == 0) begin sc_ones = b; sc_first = b; end
                    else if ((p & 3) == 0)
                    begin
                        sc_main += trap_level(sc_ones + b, 5);
                        sc_ones = b;
                    end
                    else sc_ones += b;
                    if (p + 1 == len && len == 4 * m && m > 0)
                        sc_main += trap_level(sc_ones + sc_first, 5);
                end
            end
            MODE_MIX456, MODE_MIX37:
            begin
                if (sc_mode == MODE_MIX456)
                begin
                    sz = '{4, 5, 6, 0, 0}; nseg = 3; grp = 15;
                end
                else
                begin
                    sz = '{3, 4, 5, 6, 7}; nseg = 5; grp = 25;
                end
                m = len / grp;
                start = 0;
                if (m != 0 && sc_seg < nseg)
                begin
                    for (int s = 0; s < sc_seg; s++) start += m * sz[s];
                    if (p >= start)
                    begin
                        k = sz[sc_seg];
                        j = (p - start) % k;
                        if (j == 0) sc_ones = b; else sc_ones += b;
                        if (j == k - 1)
                        begin
                            sc_main += trap_level(sc_ones, k);
                            sc_blk = (sc_blk + 1) & 63;
                            if (sc_blk >= m) begin sc_blk = 0; sc_seg++; end
                        end
                    end
                end
            end
            default:
            begin
                k = (sc_mode inside {MODE_FOLD, MODE_FOLD2, MODE_FOLD3}) ? 6 : 5;
                if (p < (len / k) * k)
                begin
                    j = p % k;
                    ma = (j < 3) ? (b ^ 1) : b;
                    mb = (j & 1) ? (b ^ 1) : b;
                    if (j == 0) begin sc_ones = b; sc_pa = ma; sc_pb = mb; end
                    else begin sc_ones += b; sc_pa += ma; sc_pb += mb; end
                    if (j == k - 1)
                    begin
                        if (k == 6)
                        begin
                            sc_main += fold_level(sc_ones);
                            sc_alt_a += 16'(fold_level(sc_pa));
                            sc_alt_b += 16'(fold_level(sc_pb));
                        end
                        else if (sc_mode == MODE_LIN)
                            sc_main += 64'(sc_blk + 1) * trap_level(sc_ones, 5);
                        else if (sc_mode == MODE_EXP)
                            sc_main += 64'(trap_level(sc_ones, 5)) << (sc_blk & 63);
                        else
                            sc_main += trap_level(sc_ones, 5);
                        sc_blk = (sc_blk + 1) & 63;
                    end
                end
            end
        endcase
        if (p + 1 < len)
            sc_pos = p + 1;
        else
        begin
            fit = sc_main;
            if ((sc_mode == MODE_FOLD2 || sc_mode == MODE_FOLD3) && sc_alt_a > fit)
                fit = 64'(sc_alt_a);
            if (sc_mode == MODE_FOLD3 && sc_alt_b > fit) fit = 64'(sc_alt_b);
            r.fitness = fit[59:0];
            r.length_error = (len % grain(sc_mode)) != 0;
            score_q.push_back(r);
            clear_scorer();
        end
    endtask

    // sender: bursts with gaps
    int burst_left = 0;
    task automatic send_bit(input logic b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, b};
        do @(posedge clk); while (!s_axis_tready);
        score_bit({31'd0, b});
        bits_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (score_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_MODE) sc_mode = val[3:0]; else sc_len_reg = val;
        clear_scorer();
    endtask

    function automatic int unsigned eff(logic [8:0] v);
        if (v < 1) return 1;
        if (v > MAX_BITS_DEF) return MAX_BITS_DEF;
        return v;
    endfunction

    // sends one chromosome; kind 0 random, 1 all ones, 2 all zeros, 3 pattern
    task automatic send_chrom(input int kind);
        int unsigned n;
        logic b;
        n = eff(sc_len_reg);
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                1: b = 1'b1;
                2: b = 1'b0;
                3: b = ((i % 6) >= 3);
                default: b = 1'($urandom_range(0, 1));
            endcase
            send_bit(b);
        end
    endtask

    // receiver stall pattern and checker
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (cycle_cnt % 37 < 26) ? ($urandom_range(0, 4) != 0) : 1'b0;
    end

    always @(posedge clk)
    begin
        score_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            scores_seen++;
            if (score_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                want = score_q.pop_front();
                if (m_axis_tdata[59:0] !== want.fitness ||
                    m_axis_tdata[60] !== want.length_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp fit %0d err %0d, got fit %0d err %0d",
                                 want.fitness, want.length_error,
                                 m_axis_tdata[59:0], m_axis_tdata[60]);
                end
            end
        end
    end

    task automatic test_directed();
        write_reg(REG_BIT_COUNT, 9'd5);
        write_reg(REG_MODE, 9'(MODE_TRAP));
        send_chrom(1); send_chrom(2);
        write_reg(REG_MODE, 9'(MODE_FOLD3));
        write_reg(REG_BIT_COUNT, 9'd6);
        send_chrom(3);
        write_reg(REG_MODE, 9'(MODE_ONEMAX));
        write_reg(REG_BIT_COUNT, 9'd0);
        send_chrom(1);
        write_reg(REG_BIT_COUNT, 9'd3);
        write_reg(REG_MODE, 9'(MODE_TRAP));
        send_chrom(0);
    endtask

    task automatic test_modes();
        logic [8:0] lens[6] = '{9'd1, 9'd25, 9'd30, 9'd50, 9'd256, 9'd511};
        for (int md = 0; md < 16; md++)
        begin
            write_reg(REG_MODE, 9'(md));
            write_reg(REG_BIT_COUNT, lens[$urandom_range(0, 3)]);
            send_chrom($urandom_range(0, 3));
        end
        write_reg(REG_MODE, 9'(MODE_EXP));
        write_reg(REG_BIT_COUNT, 9'd256);
        send_chrom(1);
        write_reg(REG_BIT_COUNT, lens[5]);
        send_chrom(0);
    endtask

    task automatic test_random();
        while (bits_sent < 1550)
        begin
            write_reg(REG_MODE, 9'($urandom_range(0, 15)));
            write_reg(REG_BIT_COUNT, 9'($urandom_range(0, 60)));
            repeat ($urandom_range(1, 3)) send_chrom($urandom_range(0, 5) == 0 ? 3 : 0);
            // abandoned chromosome then restart
            if ($urandom_range(0, 4) == 0)
            begin
                send_bit(1'($urandom_range(0, 1)));
                settle();
                cfg_we <= 1'b1; cfg_index <= REG_MODE; cfg_data <= {5'd0, sc_mode};
                @(posedge clk);
                cfg_we <= 1'b0;
                clear_scorer();
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        sc_mode = MODE_TRAP;
        sc_len_reg = 9'd250;
        clear_scorer();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_chrom(0);
        test_directed();
        test_modes();
        test_random();
        settle();
        repeat (20) @(posedge clk);
        $display("sent %0d gene bits over all sixteen mode codes, checked %0d fitness results",
                 bits_sent, scores_seen);
        if (mismatches == 0 && score_q.size() == 0)
            $display("trap_fitness_evaluator verification clean");
        else
            $display("trap_fitness_evaluator verification failed");
        $finish;
    end

endmodule

/* sim.f */
src/tfe_pkg.sv
src/tfe_fifo.sv
src/tfe_front.sv
src/tfe_back.sv
src/trap_fitness_evaluator.sv
sim/tb_trap_fitness_evaluator.sv
